### hw/rtl/bole_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bounded ordered list engine.
// No dependencies; every other file in hw/rtl but bole_ram imports this package.
package bole_pkg;

  // Store geometry
  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the transfer payloads
  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Request codes; code 7 is unused and falls to default arms
  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH_RD,
    ST_SEARCH_EV,
    ST_SHIFT_RD,
    ST_SHIFT_EV,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic [POS_W-1:0]        index;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        removed_count;
    logic [POS_W-1:0]        item_count;
    logic                    is_empty;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic search_ev;
    logic shift_ev;
    logic place;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic go_search;
    logic go_shift;
    logic go_place;
    logic hit;
    logic search_last;
    logic shift_last;
  } sts_t;

  // Sign-extend the request value, then cut it to the stored width
  function automatic logic [ITEM_WIDTH-1:0] to_item(input logic signed [VAL_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[ITEM_WIDTH-1:0];
  endfunction

  // Sign-extend a stored entry, then cut it to the result width
  function automatic logic signed [VAL_W-1:0] from_item(input logic [ITEM_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'($signed(v));
    return ext[VAL_W-1:0];
  endfunction

endpackage

### hw/rtl/bole_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the entry store of the list engine.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bole_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the list engine: sequences check, walk, place
// and result hand-off. Depends on bole_pkg.
module bole_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bole_pkg::sts_t sts,
  output bole_pkg::cmd_t cmd
);
  import bole_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.go_place)       state_nxt = ST_PLACE;
        else if (sts.go_shift)  state_nxt = ST_SHIFT_RD;
        else if (sts.go_search) state_nxt = ST_SEARCH_RD;
        else                    state_nxt = ST_DONE;
      end
      ST_SEARCH_RD: state_nxt = ST_SEARCH_EV;
      ST_SEARCH_EV: begin
        if (sts.hit && sts.op == OP_INSERT_SORTED) begin
          state_nxt = ST_SHIFT_RD;
        end else if (sts.hit || sts.search_last) begin
          state_nxt = (sts.op == OP_INSERT_SORTED) ? ST_PLACE : ST_DONE;
        end else begin
          state_nxt = ST_SEARCH_RD;
        end
      end
      ST_SHIFT_RD: state_nxt = ST_SHIFT_EV;
      ST_SHIFT_EV: begin
        if (sts.shift_last) begin
          state_nxt = (sts.op == OP_ERASE_AT) ? ST_DONE : ST_PLACE;
        end else begin
          state_nxt = ST_SHIFT_RD;
        end
      end
      ST_PLACE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.check     = (state_r == ST_CHECK);
    cmd.search_ev = (state_r == ST_SEARCH_EV);
    cmd.shift_ev  = (state_r == ST_SHIFT_EV);
    cmd.place     = (state_r == ST_PLACE);
    cmd.out_load  = (state_r == ST_DONE) && out_free;
    in_stall      = (state_r != ST_IDLE);
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.check, cmd.search_ev, cmd.shift_ev, cmd.place, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_place_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE && $past(rst_n)) |->
      ($past(state_r) == ST_CHECK || $past(state_r) == ST_SEARCH_EV ||
       $past(state_r) == ST_SHIFT_EV))
    else $error("place entered from an unexpected state");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

### hw/rtl/bole_datapath.sv
`timescale 1ns / 1ps
// Datapath of the list engine: request and capacity registers, entry count,
// walk pointers, entry store and result register. Depends on bole_pkg, bole_ram.
module bole_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bole_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [bole_pkg::CAP_W-1:0]    cfg_data,
  input  bole_pkg::cmd_t                cmd,
  output bole_pkg::sts_t                sts,
  output bole_pkg::out_item_t           out_data
);
  import bole_pkg::*;

  in_item_t               req_r;
  logic [CAP_W-1:0]       capacity_r;
  logic [CNT_W-1:0]       count_r;
  logic [ADDR_W-1:0]      scan_r;
  logic [ADDR_W-1:0]      ins_pos_r;
  logic [CNT_W-1:0]       wr_r;
  logic [CNT_W-1:0]       removed_r;
  logic                   hit_r;
  logic                   req_ok_r;
  logic [ITEM_WIDTH-1:0]  rd_item_r;
  out_item_t              out_r;

  op_t                    op;
  logic [ITEM_WIDTH-1:0]  req_item;
  logic [31:0]            pos_c, cnt_c, lim_c;
  logic                   room, count_zero, req_ok;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ITEM_WIDTH-1:0]  ram_wdata, ram_rdata;
  logic                   hit, same;
  logic                   ok_c;
  logic [CNT_W-1:0]       new_count;
  out_item_t              res;

  assign op         = op_t'(req_r.operation);
  assign req_item   = to_item(req_r.value);
  assign pos_c      = 32'(req_r.position);
  assign cnt_c      = 32'(count_r);
  assign lim_c      = (32'(capacity_r) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(capacity_r);
  assign room       = cnt_c < lim_c;
  assign count_zero = (count_r == '0);
  assign same       = (ram_rdata == req_item);

  // Validate the request against count and capacity
  always_comb begin
    case (op)
      OP_INSERT_AT:                  req_ok = (pos_c <= cnt_c) && room;
      OP_INSERT_SORTED:              req_ok = room;
      OP_ERASE_AT, OP_GET, OP_SET:   req_ok = pos_c < cnt_c;
      OP_REMOVE_ALL, OP_FIND:        req_ok = 1'b1;
      default:                       req_ok = 1'b0;
    endcase
  end

  // Search hit on the entry just read
  always_comb begin
    case (op)
      OP_INSERT_SORTED: hit = $signed(req_item) <= $signed(ram_rdata);
      OP_FIND:          hit = same;
      default:          hit = 1'b0;
    endcase
  end

  // Status toward the controller
  always_comb begin
    sts.op          = op;
    sts.go_place    = req_ok && ((op == OP_INSERT_AT && pos_c == cnt_c) ||
                                 (op == OP_INSERT_SORTED && count_zero) ||
                                 (op == OP_SET));
    sts.go_shift    = req_ok && ((op == OP_INSERT_AT && pos_c != cnt_c) ||
                                 (op == OP_ERASE_AT && pos_c + 32'd1 != cnt_c));
    sts.go_search   = req_ok && ((!count_zero && (op == OP_INSERT_SORTED ||
                                  op == OP_REMOVE_ALL || op == OP_FIND)) ||
                                 (op == OP_GET));
    sts.hit         = hit;
    sts.search_last = (op == OP_GET) || (32'(scan_r) + 32'd1 == cnt_c);
    sts.shift_last  = (op == OP_ERASE_AT) ? (32'(scan_r) + 32'd1 == cnt_c)
                                          : (scan_r == ins_pos_r);
  end

  // Store write port: shift moves, compaction, and final placement
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_r;
    ram_wdata = ram_rdata;
    if (cmd.shift_ev) begin
      ram_we    = 1'b1;
      ram_waddr = (op == OP_ERASE_AT) ? scan_r - ADDR_W'(1) : scan_r + ADDR_W'(1);
    end else if (cmd.search_ev && op == OP_REMOVE_ALL && !same) begin
      ram_we    = 1'b1;
      ram_waddr = wr_r[ADDR_W-1:0];
    end else if (cmd.place) begin
      ram_we    = 1'b1;
      ram_waddr = ins_pos_r;
      ram_wdata = req_item;
    end
  end

  bole_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  // Build the result and the count after the request
  always_comb begin
    case (op)
      OP_FIND:       ok_c = hit_r;
      OP_REMOVE_ALL: ok_c = (removed_r != '0);
      OP_INSERT_AT, OP_INSERT_SORTED, OP_ERASE_AT, OP_GET, OP_SET: ok_c = req_ok_r;
      default:       ok_c = 1'b0;
    endcase

    new_count = count_r;
    if ((op == OP_INSERT_AT || op == OP_INSERT_SORTED) && ok_c) begin
      new_count = count_r + CNT_W'(1);
    end else if (op == OP_ERASE_AT && ok_c) begin
      new_count = count_r - CNT_W'(1);
    end else if (op == OP_REMOVE_ALL) begin
      new_count = wr_r;
    end

    res               = '0;
    res.ok            = ok_c;
    if (ok_c && (op == OP_INSERT_AT || op == OP_INSERT_SORTED || op == OP_FIND)) begin
      res.index = POS_W'(ins_pos_r);
    end
    if (ok_c && op == OP_GET) begin
      res.read_value = from_item(rd_item_r);
    end
    if (op == OP_REMOVE_ALL) begin
      res.removed_count = POS_W'(removed_r);
    end
    res.item_count    = POS_W'(new_count);
    res.is_empty      = (new_count == '0);
  end

  // Control state: count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      capacity_r <= CAP_RESET;
    end else begin
      if (cfg_we)       capacity_r <= cfg_data;
      if (cmd.out_load) count_r    <= new_count;
    end
  end

  // Request, walk pointers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.check) begin
      req_ok_r  <= req_ok;
      hit_r     <= 1'b0;
      wr_r      <= '0;
      removed_r <= '0;
      case (op)
        OP_INSERT_AT: begin
          scan_r    <= ADDR_W'(count_r - CNT_W'(1));
          ins_pos_r <= req_r.position[ADDR_W-1:0];
        end
        OP_INSERT_SORTED: begin
          scan_r    <= '0;
          ins_pos_r <= count_r[ADDR_W-1:0];
        end
        OP_ERASE_AT: begin
          scan_r    <= ADDR_W'(req_r.position + POS_W'(1));
          ins_pos_r <= '0;
        end
        OP_GET, OP_SET: begin
          scan_r    <= req_r.position[ADDR_W-1:0];
          ins_pos_r <= req_r.position[ADDR_W-1:0];
        end
        default: begin
          scan_r    <= '0;
          ins_pos_r <= '0;
        end
      endcase
    end
    if (cmd.search_ev) begin
      if (op == OP_GET) rd_item_r <= ram_rdata;
      if (op == OP_REMOVE_ALL) begin
        if (same) removed_r <= removed_r + CNT_W'(1);
        else      wr_r      <= wr_r + CNT_W'(1);
      end
      if (hit) begin
        hit_r     <= 1'b1;
        ins_pos_r <= scan_r;
      end
      // advance, or turn around to shift up from the top for a sorted insert
      if (hit && op == OP_INSERT_SORTED) scan_r <= ADDR_W'(count_r - CNT_W'(1));
      else                                scan_r <= scan_r + ADDR_W'(1);
    end
    if (cmd.shift_ev) begin
      scan_r <= (op == OP_ERASE_AT) ? scan_r + ADDR_W'(1) : scan_r - ADDR_W'(1);
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above store depth");

  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_ev && op != OP_ERASE_AT) |-> (scan_r >= ins_pos_r))
    else $error("upward shift walked below the insert position");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.search_ev && op == OP_REMOVE_ALL) |-> (32'(wr_r) <= 32'(scan_r)))
    else $error("compaction write pointer passed the read pointer");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_data.is_empty == (count_r == '0)))
    else $error("result empty flag disagrees with the count");

endmodule

### hw/rtl/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// Top level of the bounded ordered list engine: controller plus datapath.
// Depends on bole_pkg, bole_ctrl, bole_datapath (and bole_ram below it).
//
// Keeps an ordered list of up to 64 signed entries in a single-port-read,
// single-port-write store with registered read data. One request is worked
// at a time. Requests that do not walk the list go from check straight to
// the result for erase of the last entry and refused requests, through
// place for set and inserts at the end, and through one store read and
// evaluate for get. Requests that search, move or compact entries visit
// each entry with a read state that addresses the store and an evaluate
// state that uses its data. The store has no clearing pass after reset;
// entries past the count are never read. The result sits in its own
// register, so a new request is taken while the last result still waits
// for its transfer. The capacity register may be written at any cycle the
// engine is idle; cfg_ready is always high.
module bounded_ordered_list_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bole_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bole_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bole_pkg::CAP_W-1:0] cfg_data
);
  import bole_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Capacity writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bole_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### verif/bole_list_check_pkg.sv
`timescale 1ns / 1ps
// Result prediction and checking for the bounded ordered list engine test.
// Depends on bole_pkg for the request and result payload types.
package bole_list_check_pkg;
  import bole_pkg::*;

  // Code 7 is not a request; the engine refuses it, reporting only the entry count and empty flag
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  class ordered_list_scoreboard;
    logic [ITEM_WIDTH-1:0] entries [DEPTH];
    int held;
    int capacity;
    out_item_t expected_results [$];
    int errors;
    int checked;
    int max_held;
    int refused_inserts;
    int find_hits;
    int removed_total;

    function new();
      held = 0;
      capacity = int'(CAP_RESET);
      errors = 0;
      checked = 0;
      max_held = 0;
      refused_inserts = 0;
      find_hits = 0;
      removed_total = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = int'(cap);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Saturate the capacity at the store depth
    function int capacity_limit();
      return (capacity > DEPTH) ? DEPTH : capacity;
    endfunction

    // Open a slot at the position and move later entries up
    function bit place(int at, logic [ITEM_WIDTH-1:0] v);
      if (at > held || held >= capacity_limit()) return 1'b0;
      for (int i = held; i > at; i--) entries[i] = entries[i-1];
      entries[at] = v;
      held++;
      return 1'b1;
    endfunction

    // Apply one accepted request to the list and queue its result
    function void note_request(in_item_t req);
      out_item_t res;
      logic [ITEM_WIDTH-1:0] v;
      int at;
      int kept;
      int gone;
      res = '0;
      v = ITEM_WIDTH'(req.value);
      at = int'(req.position);
      case (req.operation)
        OP_INSERT_AT: begin
          if (place(at, v)) begin
            res.ok = 1'b1;
            res.index = req.position;
          end
        end
        OP_INSERT_SORTED: begin
          if (held < capacity_limit()) begin
            at = held;
            for (int i = 0; i < held; i++) begin
              if ($signed(v) <= $signed(entries[i])) begin
                at = i;
                break;
              end
            end
            if (place(at, v)) begin
              res.ok = 1'b1;
              res.index = POS_W'(at);
            end
          end
        end
        OP_ERASE_AT: begin
          if (at < held) begin
            for (int i = at; i + 1 < held; i++) entries[i] = entries[i+1];
            held--;
            res.ok = 1'b1;
          end
        end
        OP_REMOVE_ALL: begin
          kept = 0;
          gone = 0;
          for (int i = 0; i < held; i++) begin
            if (entries[i] == v) gone++;
            else begin
              entries[kept] = entries[i];
              kept++;
            end
          end
          held = kept;
          res.ok = (gone != 0);
          res.removed_count = POS_W'(gone);
          removed_total += gone;
        end
        OP_GET: begin
          if (at < held) begin
            res.ok = 1'b1;
            res.read_value = entries[at];
          end
        end
        OP_SET: begin
          if (at < held) begin
            entries[at] = v;
            res.ok = 1'b1;
          end
        end
        OP_FIND: begin
          for (int i = 0; i < held; i++) begin
            if (entries[i] == v) begin
              res.ok = 1'b1;
              res.index = POS_W'(i);
              find_hits++;
              break;
            end
          end
        end
        default: ;
      endcase
      if ((req.operation == OP_INSERT_AT || req.operation == OP_INSERT_SORTED) && !res.ok)
        refused_inserts++;
      if (held > max_held) max_held = held;
      res.item_count = POS_W'(held);
      res.is_empty = (held == 0);
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Match a result transfer against the oldest outstanding request
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("ok", 64'(want.ok), 64'(got.ok));
      compare_field("index", 64'(want.index), 64'(got.index));
      compare_field("read_value", 64'($signed(want.read_value)), 64'($signed(got.read_value)));
      compare_field("removed_count", 64'(want.removed_count), 64'(got.removed_count));
      compare_field("item_count", 64'(want.item_count), 64'(got.item_count));
      compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
    endfunction
  endclass

endpackage

### verif/bounded_ordered_list_engine_test.sv
`timescale 1ns / 1ps
// Self-checking test of the bounded ordered list engine: directed corner
// requests, then random request mixes over several capacity settings.
// Depends on bole_pkg, bole_list_check_pkg and the engine RTL.
module bounded_ordered_list_engine_test;
  import bole_pkg::*;
  import bole_list_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data;

  ordered_list_scoreboard sb;
  int  gap_pct;
  int  stall_pct;
  int  long_hold_cycles;
  bit  calm;
  int  idle_cycles;
  int  settings_tried;

  bounded_ordered_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[bounded_ordered_list_engine] ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Offer one request, hold it until taken, then maybe idle a burst
  task automatic send_request(input in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int pos, input logic [31:0] v);
    in_item_t req;
    req.operation = op;
    req.position  = POS_W'(pos);
    req.value     = v;
    send_request(req);
  endtask

  // Stop offering and wait until every result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_capacity(cap);
    settings_tried++;
  endtask

  // Favor a few small values so finds, removes and sorted ties hit often
  function automatic logic [31:0] pick_value();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        k = $urandom_range(0, 6);
        return 32'(k - 3);
      end
      4:       return 32'h8000_0000 + 32'($urandom_range(0, 2));
      5:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 2));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t make_request(mix_t mix);
    in_item_t req;
    int roll;
    int insert_share;
    insert_share = (mix == MODE_FILL) ? 70 : (mix == MODE_MIX) ? 40 : 15;
    roll = $urandom_range(0, 99);
    if (roll < insert_share / 2) req.operation = OP_INSERT_AT;
    else if (roll < insert_share) req.operation = OP_INSERT_SORTED;
    else begin
      case ($urandom_range(0, 10))
        0, 1, 2: req.operation = OP_ERASE_AT;
        3:       req.operation = OP_REMOVE_ALL;
        4, 5:    req.operation = OP_GET;
        6, 7:    req.operation = OP_SET;
        8, 9:    req.operation = OP_FIND;
        default: req.operation = OP_UNUSED;
      endcase
    end
    // Mostly positions up to the current count, some anywhere in the field
    if ($urandom_range(0, 9) == 0) req.position = POS_W'($urandom_range(0, 127));
    else req.position = POS_W'($urandom_range(0, sb.held));
    req.value = pick_value();
    return req;
  endfunction

  task automatic run_random(input int n, input mix_t mix);
    repeat (n) send_request(make_request(mix));
  endtask

  initial begin : stimulus
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    gap_pct   = 0;
    stall_pct = 0;
    long_hold_cycles = 0;
    calm = 1'b0;
    idle_cycles = 0;
    settings_tried = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list requests, bad positions, extremes, ties
    send_op(OP_GET, 0, 32'd0);
    send_op(OP_ERASE_AT, 0, 32'd0);
    send_op(OP_FIND, 0, 32'd0);
    send_op(OP_REMOVE_ALL, 0, 32'd0);
    send_op(OP_SET, 0, 32'd5);
    send_op(OP_INSERT_AT, 1, 32'd1);
    send_op(OP_INSERT_AT, 0, 32'h7FFF_FFFF);
    send_op(OP_INSERT_SORTED, 0, 32'h8000_0000);
    send_op(OP_INSERT_SORTED, 0, 32'd0);
    send_op(OP_INSERT_SORTED, 0, 32'd0);
    send_op(OP_INSERT_SORTED, 0, 32'h7FFF_FFFF);
    send_op(OP_INSERT_AT, 5, 32'hFFFF_FFFF);
    send_op(OP_INSERT_AT, 64, 32'd7);
    send_op(OP_INSERT_AT, 127, 32'd7);
    send_op(OP_GET, 0, 32'd0);
    send_op(OP_GET, 5, 32'd0);
    send_op(OP_GET, 127, 32'd0);
    send_op(OP_SET, 2, 32'h5555_AAAA);
    send_op(OP_FIND, 0, 32'd0);
    send_op(OP_FIND, 0, 32'h1234_5678);
    send_op(OP_REMOVE_ALL, 0, 32'h7FFF_FFFF);
    send_op(OP_REMOVE_ALL, 0, 32'd99);
    send_op(OP_ERASE_AT, 3, 32'd0);
    send_op(OP_ERASE_AT, 0, 32'd0);
    send_op(OP_ERASE_AT, 64, 32'd0);
    send_op(OP_UNUSED, 127, 32'hFFFF_FFFF);
    drain_results();

    // Zero capacity with entries held: every insert is refused
    gap_pct = 20;
    stall_pct = 10;
    write_capacity(CAP_W'(0));
    run_random(20, MODE_MIX);
    drain_results();

    // Oversized capacity saturates; fill to full behind a long receiver hold
    write_capacity(CAP_W'(127));
    long_hold_cycles = 700;
    run_random(100, MODE_FILL);
    run_random(60, MODE_MIX);
    drain_results();

    // Capacity far below the count, then refill up to it
    gap_pct = 50;
    stall_pct = 25;
    write_capacity(CAP_W'(5));
    run_random(60, MODE_DRAIN);
    run_random(60, MODE_FILL);
    drain_results();

    gap_pct = 0;
    stall_pct = 0;
    write_capacity(CAP_W'(1));
    run_random(80, MODE_MIX);
    drain_results();

    gap_pct = 15;
    stall_pct = 5;
    write_capacity(CAP_W'(64));
    run_random(100, MODE_FILL);
    run_random(100, MODE_DRAIN);
    drain_results();

    gap_pct = 30;
    stall_pct = 30;
    write_capacity(CAP_W'(100));
    run_random(130, MODE_MIX);
    drain_results();

    // Closing stretch at full rate on both sides
    calm = 1'b1;
    write_capacity(CAP_W'(33));
    run_random(70, MODE_FILL);
    run_random(60, MODE_MIX);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d capacity settings; list peaked at %0d entries.",
             sb.checked, settings_tried, sb.max_held);
    $display("Inserts refused: %0d, finds that hit: %0d, entries removed by value: %0d.",
             sb.refused_inserts, sb.find_hits, sb.removed_total);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[bounded_ordered_list_engine] OK");
    end else begin
      $display("[bounded_ordered_list_engine] ERROR");
    end
    $finish;
  end

endmodule
